@@ hdl/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared defaults, request modes and result status codes.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int DEF_FRAME_COUNT = 1024;
   localparam int DEF_MAX_ORDER   = 6;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_BADFREE = 2'd2
   } status_type;

endpackage

@@ hdl/bpa_frame_ram.sv @@
// ----------------------------------------------------------------------------
// Frame table memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bpa_frame_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 27
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/bpa_list_heads.sv @@
// ----------------------------------------------------------------------------
// Free list heads
// One head link per order, a read port and a search for the smallest
// non-empty order at or above a wanted order.
// ----------------------------------------------------------------------------
module bpa_list_heads #(
   parameter int NUM    = 7,
   parameter int OW     = 3,
   parameter int LW     = 11,
   parameter int FRAMES = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          we,
   input  logic [OW-1:0] waddr,
   input  logic [LW-1:0] wdata,
   input  logic [OW-1:0] sel,
   output logic [LW-1:0] head,
   input  logic [OW-1:0] want,
   output logic          found,
   output logic [OW-1:0] found_ord
);

   localparam logic [LW-1:0] NIL       = LW'(FRAMES);
   localparam logic [LW-1:0] TOP_RESET = ((2 ** (NUM - 1)) <= FRAMES) ? '0 : NIL;

   logic [LW-1:0] head_ff [NUM];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM; k++) begin
            head_ff[k] <= (k == NUM - 1) ? TOP_RESET : NIL;
         end
      end else if (we) begin
         head_ff[waddr] <= wdata;
      end
   end

   assign head = head_ff[sel];

   always_comb begin
      found     = 1'b0;
      found_ord = '0;
      for (int k = NUM - 1; k >= 0; k--) begin
         if ((OW'(k) >= want) && (head_ff[k] != NIL)) begin
            found     = 1'b1;
            found_ord = OW'(k);
         end
      end
   end

endmodule

@@ hdl/buddy_page_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator
// Allocates and frees power-of-two blocks of frames with per-order free lists
// held in a frame table memory.
//
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  mode, frames_wanted, frame_index
// rsp_      out        rsp_valid/rsp_stall  status, block_frame, block_order
//
// An allocate pops the head block (A_POP, A_POPN, A_POPW if it has a successor)
// and splits one level per A_SPLIT, with A_SPLW when the lower list is not
// empty. A free checks the block (F_CHK), merges per level (F_BUD, F_MRG, F_UP,
// F_UN) and pushes it (F_PUSH, F_PUW). Each state does at most one frame table
// read and one write. After reset a pass fills the frame table; requests are
// stalled until it ends. A result waiting in the output register does not
// block the next request; the one after that waits until it drains.
// ----------------------------------------------------------------------------
module buddy_page_allocator_unit #(
   parameter int FRAME_COUNT = bpa_pkg::DEF_FRAME_COUNT,
   parameter int MAX_ORDER   = bpa_pkg::DEF_MAX_ORDER
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic [9:0]          req_frames_wanted,
   input  logic [9:0]          req_frame_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bpa_pkg::status_type rsp_status,
   output logic [9:0]          rsp_block_frame,
   output logic [2:0]          rsp_block_order
);

   import bpa_pkg::*;

   localparam int FW  = $clog2(FRAME_COUNT);
   localparam int LW  = $clog2(FRAME_COUNT + 1);
   localparam int OW  = $clog2(MAX_ORDER + 1);
   localparam int TOP = 2 ** MAX_ORDER;
   localparam int EW  = 2 + OW + 2 * LW;
   localparam logic [LW-1:0] NIL = LW'(FRAME_COUNT);

   typedef struct packed {
      logic          free;
      logic          head;
      logic [OW-1:0] tag;
      logic [LW-1:0] nxt;
      logic [LW-1:0] prv;
   } entry_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_OUT,
      A_POP, A_POPN, A_POPW, A_SPLIT, A_SPLW,
      F_CHK, F_BUD, F_MRG, F_UP, F_UN, F_PUSH, F_PUW
   } state_type;

   function automatic logic [3:0] ceil_log2(input logic [9:0] n);
      logic [3:0]  r;
      logic [10:0] nn;
      r  = 4'd0;
      nn = (n == 10'd0) ? 11'd1 : {1'b0, n};
      for (int k = 10; k >= 0; k--) begin
         if ((11'd1 << k) >= nn) begin
            r = 4'(k);
         end
      end
      return r;
   endfunction

   state_type     state_ff, state_in;
   logic [FW-1:0] f_ff, f_in;
   logic [OW-1:0] ord_ff, ord_in;
   logic [OW-1:0] cur_ff, cur_in;
   logic [LW-1:0] lp_ff, lp_in;
   logic [LW-1:0] ln_ff, ln_in;
   logic [FW-1:0] right_ff, right_in;
   logic [FW-1:0] init_ff, init_in;
   status_type    res_status_ff, res_status_in;
   logic [9:0]    res_frame_ff, res_frame_in;
   logic [OW-1:0] res_order_ff, res_order_in;
   logic          rsp_valid_ff;
   status_type    rsp_status_ff;
   logic [9:0]    rsp_frame_ff;
   logic [OW-1:0] rsp_order_ff;

   logic          mem_we, mem_re;
   logic [FW-1:0] mem_waddr, mem_raddr;
   entry_type     mem_wdata, rd;
   logic [EW-1:0] mem_rdata;

   logic          hd_we, srch_found;
   logic [OW-1:0] hd_waddr, hd_sel, srch_want, srch_ord;
   logic [LW-1:0] hd_wdata, hd_head;

   logic [3:0]    want_ord;
   logic          want_big;
   logic [31:0]   init_w, bud_w;
   logic [OW-1:0] c1;
   logic [FW-1:0] split_r;

   bpa_frame_ram #(
      .DEPTH(FRAME_COUNT), .AW(FW), .DW(EW)
   ) u_ram (
      .clock(clock), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
      .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
   );

   bpa_list_heads #(
      .NUM(MAX_ORDER + 1), .OW(OW), .LW(LW), .FRAMES(FRAME_COUNT)
   ) u_heads (
      .clock(clock), .reset(reset), .we(hd_we), .waddr(hd_waddr),
      .wdata(hd_wdata), .sel(hd_sel), .head(hd_head), .want(srch_want),
      .found(srch_found), .found_ord(srch_ord)
   );

   assign rd        = entry_type'(mem_rdata);
   assign want_ord  = ceil_log2(req_frames_wanted);
   assign want_big  = 32'(want_ord) > 32'(MAX_ORDER);
   assign srch_want = want_big ? '0 : OW'(want_ord);
   assign init_w    = 32'(init_ff);
   assign bud_w     = 32'(f_ff) ^ (32'(1) << ord_ff);
   assign c1        = cur_ff - OW'(1);
   assign split_r   = f_ff ^ (FW'(1) << c1);
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      f_in          = f_ff;
      ord_in        = ord_ff;
      cur_in        = cur_ff;
      lp_in         = lp_ff;
      ln_in         = ln_ff;
      right_in      = right_ff;
      init_in       = init_ff;
      res_status_in = res_status_ff;
      res_frame_in  = res_frame_ff;
      res_order_in  = res_order_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      hd_we         = 1'b0;
      hd_waddr      = '0;
      hd_wdata      = '0;
      hd_sel        = '0;
      case (state_ff)
         S_INIT: begin
            mem_we         = 1'b1;
            mem_waddr      = init_ff;
            mem_wdata.free = 1'b1;
            mem_wdata.head = ((init_w % TOP) == 0) && (init_w + TOP <= FRAME_COUNT);
            mem_wdata.tag  = mem_wdata.head ? OW'(MAX_ORDER) : '0;
            mem_wdata.nxt  = (mem_wdata.head && (init_w + 2 * TOP <= FRAME_COUNT)) ?
                             LW'(init_w + TOP) : NIL;
            mem_wdata.prv  = (mem_wdata.head && (init_w >= TOP)) ?
                             LW'(init_w - TOP) : NIL;
            init_in        = init_ff + FW'(1);
            if (init_ff == FW'(FRAME_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_ALLOC) begin
                  if (want_big || !srch_found) begin
                     res_status_in = ST_NOSPACE;
                     res_frame_in  = '0;
                     res_order_in  = '0;
                     state_in      = S_OUT;
                  end else begin
                     cur_in   = srch_ord;
                     ord_in   = srch_want;
                     state_in = A_POP;
                  end
               end else if (32'(req_frame_index) >= 32'(FRAME_COUNT)) begin
                  res_status_in = ST_BADFREE;
                  res_frame_in  = req_frame_index;
                  res_order_in  = '0;
                  state_in      = S_OUT;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = FW'(req_frame_index);
                  f_in      = FW'(req_frame_index);
                  state_in  = F_CHK;
               end
            end
         end
         A_POP: begin
            hd_sel    = cur_ff;
            f_in      = FW'(hd_head);
            mem_re    = 1'b1;
            mem_raddr = FW'(hd_head);
            state_in  = A_POPN;
         end
         A_POPN: begin
            hd_we    = 1'b1;
            hd_waddr = cur_ff;
            hd_wdata = rd.nxt;
            ln_in    = rd.nxt;
            if (rd.nxt != NIL) begin
               mem_re    = 1'b1;
               mem_raddr = FW'(rd.nxt);
               state_in  = A_POPW;
            end else begin
               state_in = A_SPLIT;
            end
         end
         A_POPW: begin
            mem_we        = 1'b1;
            mem_waddr     = FW'(ln_ff);
            mem_wdata     = rd;
            mem_wdata.prv = NIL;
            state_in      = A_SPLIT;
         end
         A_SPLIT: begin
            mem_we = 1'b1;
            if (cur_ff == ord_ff) begin
               mem_waddr     = f_ff;
               mem_wdata     = '{free: 1'b0, head: 1'b1, tag: ord_ff, nxt: NIL, prv: NIL};
               res_status_in = ST_OK;
               res_frame_in  = 10'(f_ff);
               res_order_in  = ord_ff;
               state_in      = S_OUT;
            end else begin
               hd_sel    = c1;
               mem_waddr = split_r;
               mem_wdata = '{free: 1'b1, head: 1'b1, tag: c1, nxt: hd_head, prv: NIL};
               hd_we     = 1'b1;
               hd_waddr  = c1;
               hd_wdata  = LW'(split_r);
               cur_in    = c1;
               right_in  = split_r;
               ln_in     = hd_head;
               if (hd_head != NIL) begin
                  mem_re    = 1'b1;
                  mem_raddr = FW'(hd_head);
                  state_in  = A_SPLW;
               end
            end
         end
         A_SPLW: begin
            mem_we        = 1'b1;
            mem_waddr     = FW'(ln_ff);
            mem_wdata     = rd;
            mem_wdata.prv = LW'(right_ff);
            state_in      = A_SPLIT;
         end
         F_CHK: begin
            if (!rd.head || rd.free) begin
               res_status_in = ST_BADFREE;
               res_frame_in  = 10'(f_ff);
               res_order_in  = '0;
               state_in      = S_OUT;
            end else begin
               ord_in   = (32'(rd.tag) > 32'(MAX_ORDER)) ? OW'(MAX_ORDER) : rd.tag;
               state_in = F_BUD;
            end
         end
         F_BUD: begin
            if ((32'(ord_ff) >= 32'(MAX_ORDER)) || (bud_w >= 32'(FRAME_COUNT))) begin
               state_in = F_PUSH;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = FW'(bud_w);
               right_in  = FW'(bud_w);
               state_in  = F_MRG;
            end
         end
         F_MRG: begin
            if (!(rd.head && rd.free && (rd.tag == ord_ff))) begin
               state_in = F_PUSH;
            end else begin
               lp_in     = rd.prv;
               ln_in     = rd.nxt;
               mem_we    = 1'b1;
               mem_waddr = (right_ff < f_ff) ? f_ff : right_ff;
               mem_wdata = '{free: 1'b0, head: 1'b0, tag: '0, nxt: NIL, prv: NIL};
               f_in      = (right_ff < f_ff) ? right_ff : f_ff;
               ord_in    = ord_ff + OW'(1);
               if (rd.prv != NIL) begin
                  mem_re    = 1'b1;
                  mem_raddr = FW'(rd.prv);
                  state_in  = F_UP;
               end else begin
                  hd_we    = 1'b1;
                  hd_waddr = ord_ff;
                  hd_wdata = rd.nxt;
                  if (rd.nxt != NIL) begin
                     mem_re    = 1'b1;
                     mem_raddr = FW'(rd.nxt);
                     state_in  = F_UN;
                  end else begin
                     state_in = F_BUD;
                  end
               end
            end
         end
         F_UP: begin
            mem_we        = 1'b1;
            mem_waddr     = FW'(lp_ff);
            mem_wdata     = rd;
            mem_wdata.nxt = ln_ff;
            if (ln_ff != NIL) begin
               mem_re    = 1'b1;
               mem_raddr = FW'(ln_ff);
               state_in  = F_UN;
            end else begin
               state_in = F_BUD;
            end
         end
         F_UN: begin
            mem_we        = 1'b1;
            mem_waddr     = FW'(ln_ff);
            mem_wdata     = rd;
            mem_wdata.prv = lp_ff;
            state_in      = F_BUD;
         end
         F_PUSH: begin
            hd_sel        = ord_ff;
            mem_we        = 1'b1;
            mem_waddr     = f_ff;
            mem_wdata     = '{free: 1'b1, head: 1'b1, tag: ord_ff, nxt: hd_head, prv: NIL};
            hd_we         = 1'b1;
            hd_waddr      = ord_ff;
            hd_wdata      = LW'(f_ff);
            ln_in         = hd_head;
            res_status_in = ST_OK;
            res_frame_in  = 10'(f_ff);
            res_order_in  = ord_ff;
            if (hd_head != NIL) begin
               mem_re    = 1'b1;
               mem_raddr = FW'(hd_head);
               state_in  = F_PUW;
            end else begin
               state_in = S_OUT;
            end
         end
         F_PUW: begin
            mem_we        = 1'b1;
            mem_waddr     = FW'(ln_ff);
            mem_wdata     = rd;
            mem_wdata.prv = LW'(f_ff);
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         if ((state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= res_status_ff;
            rsp_frame_ff  <= res_frame_ff;
            rsp_order_ff  <= res_order_ff;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      f_ff          <= f_in;
      ord_ff        <= ord_in;
      cur_ff        <= cur_in;
      lp_ff         <= lp_in;
      ln_ff         <= ln_in;
      right_ff      <= right_in;
      res_status_ff <= res_status_in;
      res_frame_ff  <= res_frame_in;
      res_order_ff  <= res_order_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_frame = rsp_frame_ff;
   assign rsp_block_order = 3'(rsp_order_ff);

`ifndef SYNTHESIS
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("frame table read and write hit the same entry");

   a_split_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == A_SPLIT) |-> (cur_ff >= ord_ff))
      else $error("split went below the wanted order");

   a_ok_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_OK)) |-> (32'(rsp_block_order) <= 32'(MAX_ORDER)))
      else $error("result order above the top order");
`endif

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives allocate and free requests into the allocator, predicts each result
// with a behavioral model of the per-order free lists, and compares every
// result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bpa_pkg::*;

   localparam int FRAMES = DEF_FRAME_COUNT;
   localparam int TOP    = DEF_MAX_ORDER;
   localparam int NIL    = FRAMES;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      status_type status;
      logic [9:0] frame;
      logic [2:0] order;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_mode = MODE_ALLOC;
   logic [9:0] req_frames_wanted = '0;
   logic [9:0] req_frame_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   status_type rsp_status;
   logic [9:0] rsp_block_frame;
   logic [2:0] rsp_block_order;

   buddy_page_allocator_unit dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   bit free_flag [FRAMES];
   bit head_flag [FRAMES];
   logic [2:0] order_tag [FRAMES];
   int next_frame [FRAMES];
   int prev_frame [FRAMES];
   int order_head [TOP+1];

   alloc_result_type pending_results[$];
   int owned_blocks[$];
   int error_count = 0;
   int results_seen = 0;
   int allocs_ok = 0;
   int frees_ok = 0;
   int rejects = 0;
   int idle_count = 0;
   bit no_idle = 1'b0;

   task automatic model_reset();
      int prev;
      prev = NIL;
      for (int i = 0; i < FRAMES; i++) begin
         free_flag[i] = 1'b1;
         head_flag[i] = 1'b0;
         order_tag[i] = '0;
         next_frame[i] = NIL;
         prev_frame[i] = NIL;
      end
      for (int i = 0; i <= TOP; i++) order_head[i] = NIL;
      for (int i = 0; i + (1 << TOP) <= FRAMES; i += (1 << TOP)) begin
         head_flag[i] = 1'b1;
         order_tag[i] = 3'(TOP);
         prev_frame[i] = prev;
         if (prev < FRAMES) next_frame[prev] = i;
         else order_head[TOP] = i;
         prev = i;
      end
   endtask

   task automatic list_insert(int f, int ord);
      int h;
      h = order_head[ord];
      next_frame[f] = h;
      prev_frame[f] = NIL;
      if (h < FRAMES) prev_frame[h] = f;
      order_head[ord] = f;
   endtask

   task automatic list_remove(int f, int ord);
      int p;
      int n;
      p = prev_frame[f];
      n = next_frame[f];
      if (p < FRAMES) next_frame[p] = n;
      else order_head[ord] = n;
      if (n < FRAMES) prev_frame[n] = p;
      next_frame[f] = NIL;
      prev_frame[f] = NIL;
   endtask

   function automatic alloc_result_type make_result(status_type s, int f, int o);
      alloc_result_type r;
      r.status = s;
      r.frame = f[9:0];
      r.order = o[2:0];
      return r;
   endfunction

   task automatic predict_allocation(logic m, logic [9:0] want, logic [9:0] idx,
                                     output alloc_result_type r);
      int n;
      int ord;
      int lvl;
      int f;
      int b;
      if (m == MODE_ALLOC) begin
         n = (want == '0) ? 1 : int'(want);
         ord = 0;
         while ((1 << ord) < n) ord++;
         lvl = ord;
         while (lvl <= TOP && order_head[lvl] >= FRAMES) lvl++;
         if (ord > TOP || lvl > TOP) begin
            r = make_result(ST_NOSPACE, 0, 0);
            return;
         end
         f = order_head[lvl];
         list_remove(f, lvl);
         while (lvl > ord) begin
            lvl--;
            b = f ^ (1 << lvl);
            head_flag[b] = 1'b1;
            free_flag[b] = 1'b1;
            order_tag[b] = 3'(lvl);
            list_insert(b, lvl);
         end
         head_flag[f] = 1'b1;
         free_flag[f] = 1'b0;
         order_tag[f] = 3'(ord);
         r = make_result(ST_OK, f, ord);
      end else begin
         if (!head_flag[idx] || free_flag[idx]) begin
            r = make_result(ST_BADFREE, int'(idx), 0);
            return;
         end
         f = int'(idx);
         ord = int'(order_tag[f]);
         while (ord < TOP) begin
            b = f ^ (1 << ord);
            if (!head_flag[b] || !free_flag[b] || int'(order_tag[b]) != ord) break;
            list_remove(b, ord);
            if (b < f) begin
               head_flag[f] = 1'b0;
               f = b;
            end else begin
               head_flag[b] = 1'b0;
            end
            ord++;
         end
         head_flag[f] = 1'b1;
         free_flag[f] = 1'b1;
         order_tag[f] = 3'(ord);
         list_insert(f, ord);
         r = make_result(ST_OK, f, ord);
      end
   endtask

   function automatic bit take_gap();
      return !no_idle && ($urandom_range(99) < 7);
   endfunction

   task automatic send_request(logic m, logic [9:0] want, logic [9:0] idx);
      alloc_result_type r;
      @(negedge clock);
      while (take_gap()) @(negedge clock);
      req_valid <= 1'b1;
      req_mode <= m;
      req_frames_wanted <= want;
      req_frame_index <= idx;
      do @(posedge clock); while (req_stall);
      predict_allocation(m, want, idx, r);
      pending_results.push_back(r);
      if (r.status == ST_OK && m == MODE_ALLOC) begin
         owned_blocks.push_back(int'(r.frame));
         allocs_ok++;
      end else if (r.status == ST_OK) begin
         frees_ok++;
      end else begin
         rejects++;
      end
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic alloc_frames(int n);
      send_request(MODE_ALLOC, n[9:0], 10'($urandom));
   endtask

   task automatic free_owned(int pick);
      int f;
      f = owned_blocks[pick];
      owned_blocks.delete(pick);
      send_request(MODE_FREE, 10'($urandom), f[9:0]);
   endtask

   task automatic drain();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset) rsp_stall <= take_gap();
   end

   always @(posedge clock) begin
      alloc_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result status=%0d frame=%0d order=%0d",
                     $time, rsp_status, rsp_block_frame, rsp_block_order);
            error_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, e.status, rsp_status);
               error_count++;
            end
            if (rsp_block_frame !== e.frame) begin
               $display("%0t: block_frame expected %0d actual %0d",
                        $time, e.frame, rsp_block_frame);
               error_count++;
            end
            if (rsp_block_order !== e.order) begin
               $display("%0t: block_order expected %0d actual %0d",
                        $time, e.order, rsp_block_order);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count > WATCHDOG_LIMIT + 2 * FRAMES) begin
         $display("%0t: watchdog expired", $time);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic test_size_extremes();
      alloc_frames(0);
      alloc_frames(1);
      alloc_frames(2);
      alloc_frames(3);
      alloc_frames(33);
      alloc_frames(64);
      alloc_frames(65);
      alloc_frames(1023);
      send_request(MODE_ALLOC, 10'h3ff, 10'h3ff);
      drain();
   endtask

   task automatic test_bad_frees();
      send_request(MODE_FREE, 10'h3ff, 10'd1);
      send_request(MODE_FREE, 10'd0, 10'h3ff);
      send_request(MODE_FREE, 10'd5, 10'd4);
      send_request(MODE_FREE, 10'd0, 10'd512);
      while (owned_blocks.size() != 0) free_owned(owned_blocks.size() - 1);
      send_request(MODE_FREE, 10'd0, 10'd0);
      drain();
   endtask

   task automatic test_exhaustion();
      for (int i = 0; i < 16; i++) alloc_frames(64);
      alloc_frames(1);
      while (owned_blocks.size() != 0) free_owned(0);
      drain();
   endtask

   task automatic test_random_mix(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         if (i == count / 3) no_idle = 1'b1;
         if (i == count / 2) begin
            no_idle = 1'b0;
            drain();
         end
         pick = $urandom_range(99);
         if (pick < 45 && owned_blocks.size() != 0)
            free_owned($urandom_range(owned_blocks.size() - 1));
         else if (pick < 50)
            send_request(MODE_FREE, 10'($urandom), 10'($urandom));
         else if (pick < 55)
            alloc_frames($urandom_range(1023));
         else if (pick < 85)
            alloc_frames($urandom_range(4));
         else
            alloc_frames($urandom_range(64));
      end
      while (owned_blocks.size() != 0)
         free_owned($urandom_range(owned_blocks.size() - 1));
      drain();
   endtask

   initial begin
      model_reset();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_size_extremes();
      test_bad_frees();
      test_exhaustion();
      test_random_mix(1400);
      $display("Covered %0d results: %0d allocations, %0d frees, %0d rejections.",
               results_seen, allocs_ok, frees_ok, rejects);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
